### sv/tme_pkg.sv
// Shared types and constants for the tape machine executor.
// Depends on nothing; the top level and tme_seq import it.
package tme_pkg;

	localparam int SIZE_W  = 17;      // tape size, next instruction index
	localparam int PTR_W   = 16;      // data pointer
	localparam int CNT_W   = 16;      // repeat count, loop target, instruction index
	localparam int CELL_W  = 8;
	localparam int OP_W    = 4;
	localparam int STAT_W  = 2;
	localparam int CFG_IDX_W = 4;

	localparam int ADDR_SPACE      = 65536; // cells reachable by a 16-bit pointer
	localparam int INIT_SIZE_RESET = 30000;

	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_SIZE    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GROWTH_DISABLED = 4'd1;

	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_MOVE_IGN = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NO_ZERO  = 2'd2;

	typedef enum logic [OP_W-1:0] {
		OP_ZERO  = 4'd0,
		OP_ADD   = 4'd1,
		OP_SUB   = 4'd2,
		OP_LEFT  = 4'd3,
		OP_RIGHT = 4'd4,
		OP_JZ    = 4'd5,
		OP_JNZ   = 4'd6,
		OP_SCANL = 4'd7,
		OP_SCANR = 4'd8,
		OP_NOP   = 4'd9
	} op_t;

	typedef enum logic [2:0] {
		S_RST_CLR,
		S_IDLE,
		S_EXEC,
		S_FETCH,
		S_SCAN,
		S_GROW,
		S_GROW_CLR
	} state_t;

	typedef struct packed {
		logic [SIZE_W-1:0] next_index;
		logic              branch_taken;
		logic [PTR_W-1:0]  data_pointer;
		logic [CELL_W-1:0] cell_value;
		logic [STAT_W-1:0] status;
	} res_t;

	typedef struct packed {
		logic              size_wr;
		logic [SIZE_W-1:0] size_val;
		logic              growth_dis;
	} cfg_t;

endpackage

### sv/tape_machine_executor.sv
// Top level of the tape machine executor: configuration registers, output
// register, sequencer and tape memory. Uses tme_pkg, tme_seq, tme_tape_ram.
//
// Usage:
//   Feed one pre-compiled instruction per beat on the input channel (opcode,
//   repeat_count, loop_target, instr_index). Each instruction yields exactly
//   one result beat on the output channel: next_index, branch_taken,
//   data_pointer, cell_value and status.
//   Configuration beats (cfg_index, cfg_data) write initial_size (index 0)
//   or growth_disabled (index 1); send them only while no instruction is in
//   flight. cfg_ready is always high.
// Sequence (one instruction at a time, set by the single tape read port):
//   zero, add, sub, jumps, no-op: one read, result from its read data.
//   left and right moves that are not ignored: a second read fetches the new cell.
//   scans: a further read for each further cell examined.
//   growing right moves: d doublings of the size, then n new cells,
//   which are zeroed one per cycle.
// Reset: arst_n sets the pointer to 0, the size to 30000 (capped at the
//   tape depth) and growth_disabled to 0; then a clearing pass writes zero
//   to every tape cell, with in_ready low.
// Stall: a result waits in the output register while out_ready is low; the
//   next instruction is accepted and runs, and holds its own result until
//   the output register frees up.
module tape_machine_executor import tme_pkg::*; #(
	parameter int TAPE_DEPTH = 65536
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SIZE_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [OP_W-1:0]      opcode,
	input  logic [CNT_W-1:0]     repeat_count,
	input  logic [CNT_W-1:0]     loop_target,
	input  logic [CNT_W-1:0]     instr_index,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [SIZE_W-1:0]    next_index,
	output logic                 branch_taken,
	output logic [PTR_W-1:0]     data_pointer,
	output logic [CELL_W-1:0]    cell_value,
	output logic [STAT_W-1:0]    status
);

	localparam int LIMIT = (TAPE_DEPTH < ADDR_SPACE) ? TAPE_DEPTH : ADDR_SPACE;
	localparam int AW    = $clog2(LIMIT);

	cfg_t  cfg;
	logic  growth_dis_q;

	res_t  res, out_q;
	logic  res_valid, res_ready;
	logic  out_valid_q;

	logic              mem_we, mem_re;
	logic [AW-1:0]     mem_waddr, mem_raddr;
	logic [CELL_W-1:0] mem_wdata, mem_rdata;

	// Configuration: always ready; size writes go straight to the sequencer.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			growth_dis_q <= 1'b0;
		end else if (cfg_valid && cfg_index == REG_GROWTH_DISABLED) begin
			growth_dis_q <= cfg_data[0];
		end
	end

	always_comb begin
		cfg.size_wr    = cfg_valid && (cfg_index == REG_INITIAL_SIZE);
		cfg.size_val   = cfg_data;
		cfg.growth_dis = growth_dis_q;
	end

	tme_seq #(
		.TAPE_DEPTH (TAPE_DEPTH),
		.LIMIT      (LIMIT),
		.AW         (AW)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.repeat_count (repeat_count),
		.loop_target  (loop_target),
		.instr_index  (instr_index),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_re       (mem_re),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata)
	);

	tme_tape_ram #(
		.DEPTH (LIMIT),
		.AW    (AW),
		.DW    (CELL_W)
	) u_tape (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Output register: take a result when empty or when the current beat
	// leaves this cycle; otherwise hold it and let the sequencer wait.
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign next_index   = out_q.next_index;
	assign branch_taken = out_q.branch_taken;
	assign data_pointer = out_q.data_pointer;
	assign cell_value   = out_q.cell_value;
	assign status       = out_q.status;

	// One instruction in flight: an accepted beat closes the input at once.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while an instruction is in flight");

	// A pending result never coexists with an open input.
	a_res_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !in_ready)
		else $error("result pending while input is open");

	// A result handed over always shows up on the output channel.
	a_res_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready) |=> out_valid)
		else $error("result beat lost at the output register");

endmodule

### sv/tme_tape_ram.sv
// Byte-wide tape memory: one write port, one read port, registered read data.
// Depends on nothing.
module tme_tape_ram #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16,
	parameter int DW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// hold read data until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/tme_seq.sv
// Instruction sequencer: holds pointer and size, runs the read-modify-write,
// scan, growth and clearing sequences against the tape memory. Uses tme_pkg.
module tme_seq import tme_pkg::*; #(
	parameter int TAPE_DEPTH = 65536,
	parameter int LIMIT      = (TAPE_DEPTH < ADDR_SPACE) ? TAPE_DEPTH : ADDR_SPACE,
	parameter int AW         = $clog2(LIMIT)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [OP_W-1:0]   opcode,
	input  logic [CNT_W-1:0]  repeat_count,
	input  logic [CNT_W-1:0]  loop_target,
	input  logic [CNT_W-1:0]  instr_index,
	output logic              res_valid,
	input  logic              res_ready,
	output res_t              res,
	output logic              mem_we,
	output logic [AW-1:0]     mem_waddr,
	output logic [CELL_W-1:0] mem_wdata,
	output logic              mem_re,
	output logic [AW-1:0]     mem_raddr,
	input  logic [CELL_W-1:0] mem_rdata
);

	localparam logic [SIZE_W-1:0] LIMIT_S = SIZE_W'(LIMIT);
	localparam logic [SIZE_W:0]   LIMIT_D = (SIZE_W+1)'(LIMIT);
	localparam logic [SIZE_W-1:0] RESET_SIZE =
		SIZE_W'((INIT_SIZE_RESET > LIMIT) ? LIMIT : INIT_SIZE_RESET);
	localparam logic [AW-1:0]     LAST_ADDR = AW'(LIMIT - 1);

	state_t state_q, state_d;

	logic [OP_W-1:0]   op_q;
	logic [CNT_W-1:0]  rep_q, tgt_q, idx_q;
	logic [PTR_W-1:0]  ptr_q, ptr_d;
	logic [SIZE_W-1:0] size_q, size_d;
	logic [PTR_W-1:0]  scan_q, scan_d;
	logic [SIZE_W-1:0] ns_q, ns_d;
	logic [AW-1:0]     clr_q, clr_d;
	logic [CELL_W-1:0] cur_q, cur_d;

	logic [SIZE_W-1:0] np;
	logic [SIZE_W:0]   dbl;
	logic [SIZE_W-1:0] cfg_size;
	logic              scan_end;

	always_comb begin
		np  = {1'b0, ptr_q} + {1'b0, rep_q};
		dbl = {ns_q, 1'b0};
		if (cfg.size_val == '0) begin
			cfg_size = SIZE_W'(1);
		end else if (cfg.size_val > LIMIT_S) begin
			cfg_size = LIMIT_S;
		end else begin
			cfg_size = cfg.size_val;
		end
		if (op_t'(op_q) == OP_SCANL) begin
			scan_end = (scan_q == '0);
		end else begin
			scan_end = (({1'b0, scan_q} + SIZE_W'(1)) >= size_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RST_CLR;
			ptr_q   <= '0;
			size_q  <= RESET_SIZE;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			ptr_q   <= ptr_d;
			size_q  <= size_d;
			clr_q   <= clr_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q  <= opcode;
			rep_q <= repeat_count;
			tgt_q <= loop_target;
			idx_q <= instr_index;
		end
		scan_q <= scan_d;
		ns_q   <= ns_d;
		cur_q  <= cur_d;
	end

	always_comb begin
		state_d   = state_q;
		ptr_d     = ptr_q;
		size_d    = size_q;
		scan_d    = scan_q;
		ns_d      = ns_q;
		clr_d     = clr_q;
		cur_d     = cur_q;
		in_ready  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = ptr_q[AW-1:0];
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = ptr_q[AW-1:0];
		res_valid = 1'b0;
		res.next_index   = {1'b0, idx_q} + SIZE_W'(1);
		res.branch_taken = 1'b0;
		res.data_pointer = ptr_q;
		res.cell_value   = mem_rdata;
		res.status       = STAT_OK;

		unique case (state_q)
			S_RST_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				if (clr_q == LAST_ADDR) begin
					clr_d   = '0;
					state_d = S_IDLE;
				end else begin
					clr_d = clr_q + AW'(1);
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					mem_re  = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				cur_d = mem_rdata;
				unique case (op_t'(op_q))
					OP_ZERO: begin
						mem_we         = 1'b1;
						res_valid      = 1'b1;
						res.cell_value = '0;
					end
					OP_ADD: begin
						mem_we         = 1'b1;
						mem_wdata      = mem_rdata + rep_q[CELL_W-1:0];
						res_valid      = 1'b1;
						res.cell_value = mem_wdata;
					end
					OP_SUB: begin
						mem_we         = 1'b1;
						mem_wdata      = mem_rdata - rep_q[CELL_W-1:0];
						res_valid      = 1'b1;
						res.cell_value = mem_wdata;
					end
					OP_LEFT: begin
						if (rep_q > ptr_q) begin
							res_valid  = 1'b1;
							res.status = STAT_MOVE_IGN;
						end else begin
							ptr_d     = ptr_q - rep_q;
							mem_re    = 1'b1;
							mem_raddr = ptr_d[AW-1:0];
							state_d   = S_FETCH;
						end
					end
					OP_RIGHT: begin
						if (np < size_q) begin
							ptr_d     = np[PTR_W-1:0];
							mem_re    = 1'b1;
							mem_raddr = ptr_d[AW-1:0];
							state_d   = S_FETCH;
						end else if (cfg.growth_dis || np >= LIMIT_S) begin
							res_valid  = 1'b1;
							res.status = STAT_MOVE_IGN;
						end else begin
							ns_d    = size_q;
							clr_d   = size_q[AW-1:0];
							state_d = S_GROW;
						end
					end
					OP_JZ: begin
						res_valid = 1'b1;
						if (mem_rdata == '0) begin
							res.branch_taken = 1'b1;
							res.next_index   = {1'b0, tgt_q} + SIZE_W'(1);
						end
					end
					OP_JNZ: begin
						res_valid = 1'b1;
						if (mem_rdata != '0) begin
							res.branch_taken = 1'b1;
							res.next_index   = {1'b0, tgt_q} + SIZE_W'(1);
						end
					end
					OP_SCANL: begin
						if (mem_rdata == '0) begin
							res_valid = 1'b1;
						end else if (ptr_q == '0) begin
							res_valid  = 1'b1;
							res.status = STAT_NO_ZERO;
						end else begin
							scan_d    = ptr_q - PTR_W'(1);
							mem_re    = 1'b1;
							mem_raddr = scan_d[AW-1:0];
							state_d   = S_SCAN;
						end
					end
					OP_SCANR: begin
						if (mem_rdata == '0) begin
							res_valid = 1'b1;
						end else if (({1'b0, ptr_q} + SIZE_W'(1)) >= size_q) begin
							res_valid  = 1'b1;
							res.status = STAT_NO_ZERO;
						end else begin
							scan_d    = ptr_q + PTR_W'(1);
							mem_re    = 1'b1;
							mem_raddr = scan_d[AW-1:0];
							state_d   = S_SCAN;
						end
					end
					default: begin
						res_valid = 1'b1;
					end
				endcase
				if (res_valid && res_ready) begin
					state_d = S_IDLE;
				end
			end
			S_FETCH: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			S_SCAN: begin
				if (mem_rdata == '0) begin
					res_valid        = 1'b1;
					res.data_pointer = scan_q;
					res.cell_value   = '0;
					ptr_d            = scan_q;
				end else if (scan_end) begin
					res_valid      = 1'b1;
					res.cell_value = cur_q;
					res.status     = STAT_NO_ZERO;
				end else begin
					if (op_t'(op_q) == OP_SCANL) begin
						scan_d = scan_q - PTR_W'(1);
					end else begin
						scan_d = scan_q + PTR_W'(1);
					end
					mem_re    = 1'b1;
					mem_raddr = scan_d[AW-1:0];
				end
				if (res_valid && res_ready) begin
					state_d = S_IDLE;
				end
			end
			S_GROW: begin
				if (np >= ns_q) begin
					ns_d = (dbl > LIMIT_D) ? LIMIT_S : dbl[SIZE_W-1:0];
				end else begin
					state_d = S_GROW_CLR;
				end
			end
			S_GROW_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				if (SIZE_W'(clr_q) == (ns_q - SIZE_W'(1))) begin
					res_valid        = 1'b1;
					res.data_pointer = np[PTR_W-1:0];
					res.cell_value   = '0;
					if (res_ready) begin
						size_d  = ns_q;
						ptr_d   = np[PTR_W-1:0];
						state_d = S_IDLE;
					end
				end else begin
					clr_d = clr_q + AW'(1);
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// size write: reload the size and pull the pointer inside it
		if (cfg.size_wr) begin
			size_d = cfg_size;
			if ({1'b0, ptr_q} >= cfg_size) begin
				ptr_d = PTR_W'(cfg_size - SIZE_W'(1));
			end
		end
	end

endmodule
